// ===== design/rsmp_pkg.sv =====
// ----------------------------------------------------------------------------
// rsmp_pkg
// Shared types and constants of the linear interpolation audio resampler.
// ----------------------------------------------------------------------------
package rsmp_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int STEP_W    = 21;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO = 1'b1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_in;
      logic                last_in;
   } req_payload_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_out;
      logic                last_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
      logic                has_prev;
   } item_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SPAN,
      BACK_HOLD
   } back_state_type;

endpackage

// ===== design/rsmp_fifo.sv =====
// ----------------------------------------------------------------------------
// rsmp_fifo
// Small register-based first-in first-out queue with occupancy count.
// ----------------------------------------------------------------------------
module rsmp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/rsmp_front.sv =====
// ----------------------------------------------------------------------------
// rsmp_front
// Accepts input transactions, tags track starts and holds the control
// registers with step clamping.
// ----------------------------------------------------------------------------
module rsmp_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  rsmp_pkg::req_payload_type      req_payload,
   output logic                           req_full,
   input  logic                           csr_write,
   input  logic [rsmp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rsmp_pkg::STEP_W-1:0]    csr_wdata,
   output logic [FRAC_BITS+4:0]           step,
   output logic                           stereo_mode,
   output logic                           item_push,
   output rsmp_pkg::item_type             item,
   input  logic                           item_full
);

   localparam int POS_W = FRAC_BITS + 5;
   localparam int CMP_W = (POS_W > rsmp_pkg::STEP_W) ? POS_W : rsmp_pkg::STEP_W;
   localparam logic [CMP_W-1:0] STEP_MIN = CMP_W'(1) << (FRAC_BITS - 5);
   localparam logic [CMP_W-1:0] STEP_MAX = CMP_W'(16) << FRAC_BITS;
   localparam logic [POS_W-1:0] STEP_ONE = POS_W'(1) << FRAC_BITS;

   logic [POS_W-1:0] step_ff, step_in;
   logic             stereo_ff, stereo_in;
   logic             have_prev_ff, have_prev_in;
   logic [CMP_W-1:0] wr_value, clamped;

   assign req_full      = item_full;
   assign item_push     = req_push && !item_full;
   assign item.sample   = req_payload.sample_in;
   assign item.last     = req_payload.last_in;
   assign item.has_prev = have_prev_ff;
   assign step          = step_ff;
   assign stereo_mode   = stereo_ff;

   // a track restarts after its final sample
   assign have_prev_in = item_push ? !req_payload.last_in : have_prev_ff;

   always_comb begin
      wr_value = CMP_W'(csr_wdata);
      if (wr_value < STEP_MIN) begin
         clamped = STEP_MIN;
      end else if (wr_value > STEP_MAX) begin
         clamped = STEP_MAX;
      end else begin
         clamped = wr_value;
      end
      step_in   = step_ff;
      stereo_in = stereo_ff;
      if (csr_write) begin
         case (csr_index)
            rsmp_pkg::CSR_STEP:   step_in   = clamped[POS_W-1:0];
            rsmp_pkg::CSR_STEREO: stereo_in = csr_wdata[0];
            default: begin
               step_in   = step_ff;
               stereo_in = stereo_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_ONE;
         stereo_ff    <= 1'b0;
         have_prev_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         stereo_ff    <= stereo_in;
         have_prev_ff <= have_prev_in;
      end
   end

endmodule

// ===== design/rsmp_back.sv =====
// ----------------------------------------------------------------------------
// rsmp_back
// Position sequencer and two-stage interpolation datapath; walks the output
// positions of each input interval and writes results to the output queue.
// ----------------------------------------------------------------------------
module rsmp_back #(
   parameter int FRAC_BITS = 16,
   parameter int OUT_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [FRAC_BITS+4:0]           step,
   input  logic                           stereo_mode,
   input  logic                           item_empty,
   input  rsmp_pkg::item_type             item,
   output logic                           item_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
   output logic                           out_push,
   output rsmp_pkg::rsp_payload_type      out_data
);

   localparam int POS_W = FRAC_BITS + 5;
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);
   localparam int PM_W  = FRAC_BITS + 18;
   localparam int PS_W  = FRAC_BITS + 10;
   localparam int NM_W  = FRAC_BITS + 18;
   localparam int NS_W  = FRAC_BITS + 10;
   localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << FRAC_BITS;
   localparam logic [POS_W-1:0] POS_TWO = POS_W'(2) << FRAC_BITS;

   rsmp_pkg::back_state_type state_ff, state_in;
   logic [15:0]      cur_ff, cur_in;
   logic [15:0]      prev_ff, prev_in;
   logic             item_last_ff, item_last_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic                    s1_valid_ff;
   logic                    s1_last_ff, s1_stereo_ff;
   logic signed [15:0]      s1_base_m_ff;
   logic signed [PM_W-1:0]  s1_prod_m_ff;
   logic signed [7:0]       s1_base_l_ff, s1_base_r_ff;
   logic signed [PS_W-1:0]  s1_prod_l_ff, s1_prod_r_ff;

   logic [POS_W-1:0]       nxt;
   logic                   room, active, emit, more;
   logic [15:0]            a_word, b_word;
   logic signed [FRAC_BITS:0] frac_s;
   logic signed [16:0]     diff_m;
   logic signed [8:0]      diff_l, diff_r;
   logic signed [PM_W-1:0] prod_m;
   logic signed [PS_W-1:0] prod_l, prod_r;
   logic signed [NM_W-1:0] num_m, rnd_m;
   logic signed [NS_W-1:0] num_l, rnd_l, num_r, rnd_r;

   assign nxt    = pos_ff + step;
   assign room   = ((CNT_W + 1)'(out_count) + (CNT_W + 1)'(s1_valid_ff))
                   < (CNT_W + 1)'(OUT_DEPTH);
   assign active = (state_ff == rsmp_pkg::BACK_SPAN) || (state_ff == rsmp_pkg::BACK_HOLD);
   assign emit   = active && (pos_ff < POS_ONE) && room;
   // another output follows in this interval or in the end-of-track hold
   assign more   = (nxt < POS_ONE) ||
                   ((state_ff == rsmp_pkg::BACK_SPAN) && item_last_ff && (nxt < POS_TWO));

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      item_last_in = item_last_ff;
      pos_in       = pos_ff;
      item_pop     = 1'b0;
      case (state_ff)
         rsmp_pkg::BACK_IDLE: begin
            if (!item_empty) begin
               item_pop     = 1'b1;
               cur_in       = item.sample;
               item_last_in = item.last;
               if (item.has_prev) begin
                  state_in = rsmp_pkg::BACK_SPAN;
               end else begin
                  prev_in  = item.sample;
                  state_in = item.last ? rsmp_pkg::BACK_HOLD : rsmp_pkg::BACK_IDLE;
               end
            end
         end
         rsmp_pkg::BACK_SPAN: begin
            if (pos_ff < POS_ONE) begin
               if (room) begin
                  pos_in = nxt;
               end
            end else begin
               pos_in   = pos_ff - POS_ONE;
               prev_in  = cur_ff;
               state_in = item_last_ff ? rsmp_pkg::BACK_HOLD : rsmp_pkg::BACK_IDLE;
            end
         end
         rsmp_pkg::BACK_HOLD: begin
            if (pos_ff < POS_ONE) begin
               if (room) begin
                  pos_in = nxt;
               end
            end else begin
               pos_in   = '0;
               prev_in  = '0;
               state_in = rsmp_pkg::BACK_IDLE;
            end
         end
         default: state_in = rsmp_pkg::BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsmp_pkg::BACK_IDLE;
         prev_ff      <= '0;
         pos_ff       <= '0;
         cur_ff       <= '0;
         item_last_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         pos_ff       <= pos_in;
         cur_ff       <= cur_in;
         item_last_ff <= item_last_in;
         s1_valid_ff  <= emit;
      end
   end

   // stage one: per-channel difference times fraction
   always_comb begin
      a_word = (state_ff == rsmp_pkg::BACK_HOLD) ? cur_ff : prev_ff;
      b_word = cur_ff;
      frac_s = $signed({1'b0, pos_ff[FRAC_BITS-1:0]});
      diff_m = 17'($signed(b_word)) - 17'($signed(a_word));
      diff_l = 9'($signed(b_word[15:8])) - 9'($signed(a_word[15:8]));
      diff_r = 9'($signed(b_word[7:0])) - 9'($signed(a_word[7:0]));
      prod_m = PM_W'(diff_m) * PM_W'(frac_s);
      prod_l = PS_W'(diff_l) * PS_W'(frac_s);
      prod_r = PS_W'(diff_r) * PS_W'(frac_s);
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         s1_last_ff   <= item_last_ff && !more;
         s1_stereo_ff <= stereo_mode;
         s1_base_m_ff <= $signed(a_word);
         s1_base_l_ff <= $signed(a_word[15:8]);
         s1_base_r_ff <= $signed(a_word[7:0]);
         s1_prod_m_ff <= prod_m;
         s1_prod_l_ff <= prod_l;
         s1_prod_r_ff <= prod_r;
      end
   end

   // stage two: add base, truncate toward zero, repack
   always_comb begin
      num_m = (NM_W'(s1_base_m_ff) <<< FRAC_BITS) + NM_W'(s1_prod_m_ff);
      num_l = (NS_W'(s1_base_l_ff) <<< FRAC_BITS) + NS_W'(s1_prod_l_ff);
      num_r = (NS_W'(s1_base_r_ff) <<< FRAC_BITS) + NS_W'(s1_prod_r_ff);
      rnd_m = num_m[NM_W-1] ? num_m + NM_W'((64'd1 << FRAC_BITS) - 64'd1) : num_m;
      rnd_l = num_l[NS_W-1] ? num_l + NS_W'((64'd1 << FRAC_BITS) - 64'd1) : num_l;
      rnd_r = num_r[NS_W-1] ? num_r + NS_W'((64'd1 << FRAC_BITS) - 64'd1) : num_r;
      out_data.last_out   = s1_last_ff;
      out_data.sample_out = s1_stereo_ff ?
                            {rnd_l[FRAC_BITS+7:FRAC_BITS], rnd_r[FRAC_BITS+7:FRAC_BITS]} :
                            rnd_m[FRAC_BITS+15:FRAC_BITS];
   end

   assign out_push = s1_valid_ff;

endmodule

// ===== design/linear_interp_audio_resampler.sv =====
// ----------------------------------------------------------------------------
// linear_interp_audio_resampler
// Linear interpolation audio resampler: front end with control registers,
// item queue, position sequencer with interpolation pipeline, result queue.
// ----------------------------------------------------------------------------
// path: an input transaction passes the item queue, the sequencer, the stage-one register and
// the result queue; throughput: the sequencer takes an item, gives one output per cycle while
// the result queue has room, then closes each interval (a track's final sample also runs the
// end-of-track hold); the step register sets the number of outputs per interval
// reset: synchronous, clears both queues and track state, step returns to 1.0
module linear_interp_audio_resampler #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  rsmp_pkg::req_payload_type      req_payload,
   output logic                           req_full,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output rsmp_pkg::rsp_payload_type      rsp_payload,
   input  logic                           csr_write,
   input  logic [rsmp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rsmp_pkg::STEP_W-1:0]    csr_wdata
);

   localparam int ITEM_DEPTH = 2;
   localparam int OUT_DEPTH  = 4;
   localparam int ITEM_W     = $bits(rsmp_pkg::item_type);
   localparam int RSP_W      = $bits(rsmp_pkg::rsp_payload_type);

   logic [FRAC_BITS+4:0]              step;
   logic                              stereo_mode;
   logic                              item_push, item_full, item_empty, item_pop;
   rsmp_pkg::item_type                item_wr, item_rd;
   logic [ITEM_W-1:0]                 item_rd_bits;
   logic [$clog2(ITEM_DEPTH+1)-1:0]   item_count;
   logic                              out_push, out_full;
   rsmp_pkg::rsp_payload_type         out_data;
   logic [RSP_W-1:0]                  rsp_bits;
   logic [$clog2(OUT_DEPTH+1)-1:0]    out_count;

   rsmp_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .step        (step),
      .stereo_mode (stereo_mode),
      .item_push   (item_push),
      .item        (item_wr),
      .item_full   (item_full)
   );

   rsmp_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (ITEM_DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_push),
      .push_data (item_wr),
      .pop       (item_pop),
      .pop_data  (item_rd_bits),
      .full      (item_full),
      .empty     (item_empty),
      .count     (item_count)
   );

   assign item_rd = rsmp_pkg::item_type'(item_rd_bits);

   rsmp_back #(
      .FRAC_BITS (FRAC_BITS),
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .stereo_mode (stereo_mode),
      .item_empty  (item_empty),
      .item        (item_rd),
      .item_pop    (item_pop),
      .out_count   (out_count),
      .out_push    (out_push),
      .out_data    (out_data)
   );

   rsmp_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push && (item_count <= 2'(ITEM_DEPTH) || !out_full)),
      .push_data (out_data),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .full      (out_full),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   assign rsp_payload = rsmp_pkg::rsp_payload_type'(rsp_bits);

endmodule

// ===== tb/sv/linear_interp_audio_resampler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_audio_resampler_test
// Self-checking testbench of the linear interpolation audio resampler. A
// predictor tracks the previous word, the output position and the track
// state, and queues every expected output; a checker compares each popped
// output with the oldest one. Directed tests cover sample extremes, mono
// and stereo packing, step clamping, skipped samples, silent track ends and
// a step change inside a track; a pressure test fills the block; random
// tracks follow under several step and packing settings with random idling.
// ----------------------------------------------------------------------------
module linear_interp_audio_resampler_test;

   localparam int          FRAC_BITS  = 16;
   localparam int unsigned POS_ONE    = 32'd1 << FRAC_BITS;
   localparam int unsigned STEP_MIN   = 32'd1 << (FRAC_BITS - 5);
   localparam int unsigned STEP_MAX   = 32'd16 << FRAC_BITS;
   localparam int          SETTLE     = 150;
   localparam int          MAX_CYCLES = 1000000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_push = 1'b0;
   rsmp_pkg::req_payload_type      req_payload = '0;
   logic                           req_full;
   logic                           rsp_empty;
   logic                           rsp_pop = 1'b0;
   rsmp_pkg::rsp_payload_type      rsp_payload;
   logic                           csr_write = 1'b0;
   logic [rsmp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rsmp_pkg::STEP_W-1:0]    csr_wdata = '0;

   // resampler state as predicted
   int unsigned step_val  = POS_ONE;
   bit          stereo_on = 1'b0;
   logic [15:0] prev_word = '0;
   int unsigned out_pos   = 0;
   bit          have_prev = 1'b0;

   rsmp_pkg::rsp_payload_type pending_outputs[$];

   bit tx_idle     = 1'b0;
   bit rx_idle     = 1'b0;
   int hold_cycles = 0;

   int errors          = 0;
   int words_sent      = 0;
   int outputs_checked = 0;
   int tracks_closed   = 0;
   int cycles          = 0;

   linear_interp_audio_resampler #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_payload(req_payload),
      .req_full(req_full),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_payload(rsp_payload),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > MAX_CYCLES) begin
         $display("timeout after %0d cycles, %0d outputs outstanding", cycles,
                  pending_outputs.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic int interp(input int a, input int b, input int unsigned frac);
      longint num;
      num = longint'(a) * longint'(POS_ONE) + longint'(b - a) * longint'(frac);
      return int'(num / longint'(POS_ONE));
   endfunction

   function automatic logic [15:0] mix_word(input logic [15:0] a, input logic [15:0] b,
                                            input int unsigned frac);
      int l;
      int r;
      if (stereo_on) begin
         l = interp(int'($signed(a[15:8])), int'($signed(b[15:8])), frac);
         r = interp(int'($signed(a[7:0])), int'($signed(b[7:0])), frac);
         return {l[7:0], r[7:0]};
      end
      l = interp(int'($signed(a)), int'($signed(b)), frac);
      return l[15:0];
   endfunction

   // every position in [0, 1) between two words, then one sample on
   function automatic int emit_interval(input logic [15:0] a, input logic [15:0] b,
                                        input int n);
      rsmp_pkg::rsp_payload_type r;
      int                        count;
      count = n;
      while (out_pos < POS_ONE && count < 64) begin
         r.sample_out = mix_word(a, b, out_pos);
         r.last_out   = 1'b0;
         pending_outputs.push_back(r);
         count++;
         out_pos += step_val;
      end
      if (out_pos >= POS_ONE)
         out_pos -= POS_ONE;
      return count;
   endfunction

   function automatic void predict_word(input rsmp_pkg::req_payload_type p);
      int                        n;
      rsmp_pkg::rsp_payload_type r;
      n = 0;
      if (have_prev)
         n = emit_interval(prev_word, p.sample_in, n);
      prev_word = p.sample_in;
      have_prev = 1'b1;
      if (p.last_in) begin
         n = emit_interval(p.sample_in, p.sample_in, n);
         if (n > 0) begin
            r = pending_outputs.pop_back();
            r.last_out = 1'b1;
            pending_outputs.push_back(r);
         end
         prev_word = '0;
         out_pos   = 0;
         have_prev = 1'b0;
         tracks_closed++;
      end
   endfunction

   function automatic void apply_config(input logic [rsmp_pkg::CSR_IDX_W-1:0] idx,
                                        input logic [rsmp_pkg::STEP_W-1:0] data);
      int unsigned v;
      if (idx == rsmp_pkg::CSR_STEP) begin
         v = data;
         if (v < STEP_MIN) v = STEP_MIN;
         if (v > STEP_MAX) v = STEP_MAX;
         step_val = v;
      end else if (idx == rsmp_pkg::CSR_STEREO) begin
         stereo_on = data[0];
      end
   endfunction

   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h7fff;
         3: return 16'h8000;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // output checker and receiver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_outputs
      rsmp_pkg::rsp_payload_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_outputs.size() == 0) begin
            $error("unexpected output transaction: sample_out %h last_out %b",
                   rsp_payload.sample_out, rsp_payload.last_out);
            errors++;
         end else begin
            want = pending_outputs.pop_front();
            outputs_checked++;
            if (rsp_payload.sample_out !== want.sample_out) begin
               $error("sample_out: expected %h, actual %h", want.sample_out,
                      rsp_payload.sample_out);
               errors++;
            end
            if (rsp_payload.last_out !== want.last_out) begin
               $error("last_out: expected %b, actual %b", want.last_out,
                      rsp_payload.last_out);
               errors++;
            end
         end
      end
   end

   initial begin : receiver
      int gap;
      wait (reset == 1'b0);
      forever begin
         if (hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         gap = rx_idle ? $urandom_range(0, 16) : 0;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty && hold_cycles == 0);
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic send_word(input logic [15:0] word, input logic last);
      int                        gap;
      rsmp_pkg::req_payload_type p;
      p.sample_in = word;
      p.last_in   = last;
      gap = tx_idle ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_full);
      predict_word(p);
      words_sent++;
   endtask

   // stop offering, wait for every expected output, then let the block go quiet
   task automatic quiesce();
      req_push <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rsmp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rsmp_pkg::STEP_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      apply_config(idx, data);
   endtask

   task automatic set_mode(input logic [rsmp_pkg::STEP_W-1:0] step_data, input bit stereo);
      quiesce();
      write_reg(rsmp_pkg::CSR_STEP, step_data);
      write_reg(rsmp_pkg::CSR_STEREO, rsmp_pkg::STEP_W'(stereo));
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_directed_mono();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      set_mode(21'h008000, 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(16'h7fff, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word(16'hffff, 1'b0);
      send_word(16'h0001, 1'b1);
      // track of a single sample
      send_word(16'h8000, 1'b1);
   endtask

   task automatic test_directed_stereo();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      set_mode(21'h00c000, 1'b1);
      send_word(16'h7f80, 1'b0);
      send_word(16'h807f, 1'b0);
      send_word(16'hff01, 1'b0);
      send_word(16'h0100, 1'b0);
      send_word(16'h0000, 1'b1);
   endtask

   task automatic test_step_limits();
      tx_idle = 1'b1;
      rx_idle = 1'b0;
      // below range, saturates to the smallest step
      set_mode(21'h000000, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word(16'h7fff, 1'b1);
      // above range, saturates to the largest step: samples are skipped and
      // the final sample produces nothing
      set_mode(21'h1fffff, 1'b0);
      send_word(16'h1234, 1'b0);
      send_word(16'hedcb, 1'b0);
      send_word(16'h5a5a, 1'b0);
      send_word(16'ha5a5, 1'b0);
      send_word(16'h0f0f, 1'b1);
      send_word(16'hf0f0, 1'b1);
      set_mode(21'h010000, 1'b0);
      send_word(16'h4000, 1'b0);
      send_word(16'hc000, 1'b1);
   endtask

   task automatic test_step_change_mid_track();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      set_mode(21'h006000, 1'b0);
      send_word(16'h1000, 1'b0);
      send_word(16'hf000, 1'b0);
      send_word(16'h7fff, 1'b0);
      set_mode(21'h015f90, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word(16'h0123, 1'b0);
      send_word(16'hfedc, 1'b1);
   endtask

   task automatic test_backpressure();
      int i;
      tx_idle = 1'b0;
      rx_idle = 1'b1;
      set_mode(21'h004000, 1'b1);
      hold_cycles = 1500;
      for (i = 0; i < 40; i++)
         send_word(rand_word(), i == 39);
      // sender waits for every expected output before going on
      req_push <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      send_word(rand_word(), 1'b0);
      send_word(rand_word(), 1'b1);
   endtask

   task automatic test_random();
      int                          phase;
      int                          i;
      int                          remaining;
      bit                          last;
      bit                          stereo;
      logic [rsmp_pkg::STEP_W-1:0] step_data;
      for (phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 5))
            0: step_data = rsmp_pkg::STEP_W'($urandom_range(2048, 8192));
            1: step_data = rsmp_pkg::STEP_W'($urandom_range(8192, 65536));
            2: step_data = rsmp_pkg::STEP_W'($urandom_range(65536, 262144));
            3: step_data = rsmp_pkg::STEP_W'($urandom_range(262144, 1048576));
            4: step_data = rsmp_pkg::STEP_W'($urandom_range(0, 2097151));
            default: step_data = rsmp_pkg::STEP_W'(POS_ONE);
         endcase
         if (phase == 0)
            step_data = rsmp_pkg::STEP_W'($urandom_range(0, 2097151));
         stereo = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
         set_mode(step_data, stereo);
         tx_idle = (phase == 2) ? 1'b0 : 1'($urandom_range(0, 1));
         rx_idle = (phase == 2) ? 1'b0 : 1'($urandom_range(0, 1));
         remaining = $urandom_range(1, 8);
         // tracks of random length, some cut short at random
         for (i = 0; i < 9; i++) begin
            remaining--;
            last = (remaining == 0) || ($urandom_range(0, 9) == 0);
            if (last)
               remaining = $urandom_range(1, 8);
            send_word(rand_word(), last);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_mono();
      test_directed_stereo();
      test_step_limits();
      test_step_change_mid_track();
      test_backpressure();
      test_random();
      quiesce();
      $display("run covered %0d input words, %0d tracks closed, %0d outputs checked",
               words_sent, tracks_closed, outputs_checked);
      $display("mono and stereo, clamped and in-range steps, long output stall");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/rsmp_pkg.sv
design/rsmp_fifo.sv
design/rsmp_front.sv
design/rsmp_back.sv
design/linear_interp_audio_resampler.sv
tb/sv/linear_interp_audio_resampler_test.sv
